[design/m3asm_pkg.sv]
// shared types and constants for the 3x3 matrix add / subtract / multiply unit
`default_nettype none

package m3asm_pkg;

    // result element width (two's complement, wraps beyond this)
    localparam int VALUE_WIDTH = 33;
    localparam int OP_WIDTH    = 2;

    // operation register codes
    typedef enum logic [OP_WIDTH-1:0] {
        OP_NONE = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2,
        OP_MUL  = 2'd3
    } op_t;

    // one loaded matrix pair waiting for the compute side
    typedef struct packed {
        op_t op;
    } job_t;

    // job queue status seen by both sides
    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

endpackage : m3asm_pkg

`default_nettype wire

[design/m3asm_ram.sv]
// generic single-write, single-read RAM with registered read data
`default_nettype none

module m3asm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire                      clk,
    input  wire                      wr_en,
    input  wire  [$clog2(DEPTH)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]         wr_data,
    input  wire                      rd_en,
    input  wire  [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : m3asm_ram

`default_nettype wire

[design/m3asm_front.sv]
// loader: takes elements, fills the current bank of A and B, queues a job per pair
`default_nettype none

module m3asm_front
    import m3asm_pkg::*;
#(
    parameter int DIM           = 3,
    parameter int ELEMENT_WIDTH = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [ELEMENT_WIDTH-1:0]            element,
    input  wire                                 cfg_wr_en,
    input  wire  [OP_WIDTH-1:0]                 cfg_wr_data,
    input  wire  q_status_t                     q_status,
    output logic                                push,
    output job_t                                push_job,
    output logic                                wr_en_a,
    output logic                                wr_en_b,
    output logic [$clog2(DIM*DIM*2)-1:0]        wr_addr,
    output logic [ELEMENT_WIDTH-1:0]            wr_data,
    output logic                                wr_bank
);

    localparam int CELLS = DIM * DIM;
    localparam int IW    = $clog2(CELLS);
    localparam int LW    = $clog2(2 * CELLS);

    logic [LW-1:0] load_count_reg;
    logic [LW-1:0] load_count_next;
    logic          wr_bank_reg;
    logic          wr_bank_next;
    op_t           operation_reg;
    logic          accept;
    logic          in_b;
    logic [IW-1:0] cell_idx;

    // a bank is free unless both hold pending jobs
    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // store address within the bank
    assign in_b     = (load_count_reg >= LW'(CELLS));
    assign cell_idx = in_b ? IW'(load_count_reg - LW'(CELLS)) : IW'(load_count_reg);
    assign wr_addr  = {wr_bank_reg, cell_idx};
    assign wr_data  = element;
    assign wr_en_a  = accept && !in_b;
    assign wr_en_b  = accept && in_b;
    assign wr_bank  = wr_bank_reg;

    // job issue on the final element of B
    assign push          = accept && (load_count_reg == LW'(2 * CELLS - 1));
    assign push_job.op   = operation_reg;

    // count and bank advance
    always_comb
    begin
        load_count_next = load_count_reg;
        wr_bank_next    = wr_bank_reg;
        if (push)
        begin
            load_count_next = '0;
            wr_bank_next    = !wr_bank_reg;
        end
        else if (accept)
        begin
            load_count_next = load_count_reg + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
            wr_bank_reg    <= 1'b0;
            operation_reg  <= OP_ADD;
        end
        else
        begin
            load_count_reg <= load_count_next;
            wr_bank_reg    <= wr_bank_next;
            if (cfg_wr_en)
            begin
                operation_reg <= op_t'(cfg_wr_data);
            end
        end
    end

endmodule : m3asm_front

`default_nettype wire

[design/m3asm_queue.sv]
// two-entry job queue, one entry per matrix bank
`default_nettype none

module m3asm_queue
    import m3asm_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        push,
    input  wire job_t  push_job,
    input  wire        pop,
    output job_t       head_job,
    output q_status_t  status
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign head_job     = entry_reg[rd_ptr_reg];
    assign status.valid = (count_reg != 2'd0);
    assign status.full  = (count_reg == 2'd2);

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule : m3asm_queue

`default_nettype wire

[design/m3asm_back.sv]
// compute engine: walks cells of the head job through read, multiply/add, accumulate
`default_nettype none

module m3asm_back
    import m3asm_pkg::*;
#(
    parameter int DIM           = 3,
    parameter int ELEMENT_WIDTH = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire  q_status_t                     q_status,
    input  wire  job_t                          head_job,
    output logic                                pop,
    output logic                                rd_en,
    output logic [$clog2(DIM*DIM*2)-1:0]        rd_addr_a,
    output logic [$clog2(DIM*DIM*2)-1:0]        rd_addr_b,
    input  wire  [ELEMENT_WIDTH-1:0]            rd_data_a,
    input  wire  [ELEMENT_WIDTH-1:0]            rd_data_b,
    output logic                                rd_bank,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [VALUE_WIDTH-1:0]              out_value,
    output logic                                out_last
);

    localparam int CW = $clog2(DIM);
    localparam int IW = $clog2(DIM * DIM);

    typedef struct packed {
        logic valid;
        op_t  op;
        logic first;
        logic lastk;
        logic lastcell;
    } tag_t;

    logic                          en;
    logic                          issue;
    tag_t                          issue_tag;
    tag_t                          s1_reg;
    tag_t                          s2_reg;
    logic signed [VALUE_WIDTH-1:0] term_reg;
    logic signed [VALUE_WIDTH-1:0] term_next;
    logic signed [VALUE_WIDTH-1:0] acc_reg;
    logic signed [VALUE_WIDTH-1:0] acc_next;
    logic signed [VALUE_WIDTH-1:0] opd_a;
    logic signed [VALUE_WIDTH-1:0] opd_b;
    logic [CW-1:0]                 row_reg;
    logic [CW-1:0]                 col_reg;
    logic [CW-1:0]                 k_reg;
    logic [CW-1:0]                 row_next;
    logic [CW-1:0]                 col_next;
    logic [CW-1:0]                 k_next;
    logic                          rd_bank_reg;
    logic [IW-1:0]                 idx_a;
    logic [IW-1:0]                 idx_b;
    logic                          out_valid_reg;
    logic [VALUE_WIDTH-1:0]        out_value_reg;
    logic                          out_last_reg;

    // whole pipeline moves unless a finished result is stuck
    assign en    = !out_valid_reg || out_ready;
    assign issue = en && q_status.valid;

    // tags for the read being issued
    always_comb
    begin
        issue_tag.valid    = q_status.valid;
        issue_tag.op       = head_job.op;
        issue_tag.first    = (k_reg == '0);
        issue_tag.lastk    = (head_job.op != OP_MUL) || (k_reg == CW'(DIM - 1));
        issue_tag.lastcell = issue_tag.lastk && (row_reg == CW'(DIM - 1))
                             && (col_reg == CW'(DIM - 1));
    end

    // element addresses: row/k of A, k/col of B; same cell for add and subtract
    always_comb
    begin
        if (head_job.op == OP_MUL)
        begin
            idx_a = IW'(int'(row_reg) * DIM + int'(k_reg));
            idx_b = IW'(int'(k_reg) * DIM + int'(col_reg));
        end
        else
        begin
            idx_a = IW'(int'(row_reg) * DIM + int'(col_reg));
            idx_b = idx_a;
        end
    end

    assign rd_en     = en;
    assign rd_addr_a = {rd_bank_reg, idx_a};
    assign rd_addr_b = {rd_bank_reg, idx_b};
    assign rd_bank   = rd_bank_reg;
    assign pop       = issue && issue_tag.lastcell;

    // loop counters
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        k_next   = k_reg;
        if (issue)
        begin
            if (!issue_tag.lastk)
            begin
                k_next = k_reg + CW'(1);
            end
            else
            begin
                k_next = '0;
                if (col_reg == CW'(DIM - 1))
                begin
                    col_next = '0;
                    row_next = (row_reg == CW'(DIM - 1)) ? '0 : row_reg + CW'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
        end
    end

    // one term: product, sum or difference, low bits kept
    assign opd_a = VALUE_WIDTH'($signed(rd_data_a));
    assign opd_b = VALUE_WIDTH'($signed(rd_data_b));

    always_comb
    begin
        case (s1_reg.op)
            OP_ADD:  term_next = opd_a + opd_b;
            OP_SUB:  term_next = opd_a - opd_b;
            OP_MUL:  term_next = opd_a * opd_b;
            default: term_next = '0;
        endcase
    end

    // accumulate over k
    assign acc_next = s2_reg.first ? term_reg : acc_reg + term_reg;

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term_reg <= term_next;
            if (s2_reg.valid)
            begin
                acc_reg <= acc_next;
            end
            if (s2_reg.valid && s2_reg.lastk)
            begin
                out_value_reg <= acc_next;
                out_last_reg  <= s2_reg.lastcell;
            end
        end
    end

    // control stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            rd_bank_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            k_reg   <= k_next;
            if (pop)
            begin
                rd_bank_reg <= !rd_bank_reg;
            end
            if (en)
            begin
                s1_reg        <= issue_tag;
                s2_reg        <= s1_reg;
                out_valid_reg <= s2_reg.valid && s2_reg.lastk;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule : m3asm_back

`default_nettype wire

[design/matrix3_add_sub_mul_unit.sv]
// Top level: DIM x DIM matrix add / subtract / multiply with double-banked operand stores.
// A job is queued on the final element of B; the engine then reads A and B, forms each term,
// accumulates over k and registers the result.
// Loading takes one element per accepted transfer; the single shared MAC works through one
// pair while another pair loads into the other bank.
// Reset: control, job queue and operation (add) cleared; operand stores are not cleared.
`default_nettype none

module matrix3_add_sub_mul_unit
    import m3asm_pkg::*;
#(
    parameter int DIM           = 3,
    parameter int ELEMENT_WIDTH = 16
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     s_axis_tvalid,
    output logic                                    s_axis_tready,
    // element (bits ELEMENT_WIDTH-1:0), zero fill above
    input  wire  [((ELEMENT_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire                                     m_axis_tready,
    // value (bits 32:0), zero fill above
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
    output logic                                    m_axis_tlast,
    input  wire                                     cfg_wr_en,
    input  wire  [OP_WIDTH-1:0]                     cfg_wr_data
);

    localparam int AW = $clog2(DIM * DIM * 2);
    localparam int DW = ((VALUE_WIDTH + 7) / 8) * 8;

    q_status_t                q_status;
    job_t                     push_job;
    job_t                     head_job;
    logic                     push;
    logic                     pop;
    logic                     wr_en_a;
    logic                     wr_en_b;
    logic [AW-1:0]            wr_addr;
    logic [ELEMENT_WIDTH-1:0] wr_data;
    logic                     wr_bank;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr_a;
    logic [AW-1:0]            rd_addr_b;
    logic [ELEMENT_WIDTH-1:0] rd_data_a;
    logic [ELEMENT_WIDTH-1:0] rd_data_b;
    logic                     rd_bank;
    logic [VALUE_WIDTH-1:0]   out_value;

    // loader
    m3asm_front #(
        .DIM           (DIM),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .element     (s_axis_tdata[ELEMENT_WIDTH-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_status    (q_status),
        .push        (push),
        .push_job    (push_job),
        .wr_en_a     (wr_en_a),
        .wr_en_b     (wr_en_b),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .wr_bank     (wr_bank)
    );

    // job queue
    m3asm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // operand stores, two banks each
    m3asm_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (2 ** AW)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_en_a),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    m3asm_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (2 ** AW)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_en_b),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    // compute engine
    m3asm_back #(
        .DIM           (DIM),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head_job  (head_job),
        .pop       (pop),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .rd_bank   (rd_bank),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (out_value),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = DW'(out_value);

    // loader never writes the bank the engine still reads
    a_bank_apart: assert property (@(posedge clk) disable iff (!rst_n)
        ((wr_en_a || wr_en_b) && q_status.valid) |-> (wr_bank != rd_bank))
        else $error("loader writes a bank with a pending job");

    // no job is queued while both banks are taken
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> !q_status.full)
        else $error("job queue overflow");

    // a finished pair frees its bank in the next cycle
    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> !q_status.full)
        else $error("bank not released after last read");

endmodule : matrix3_add_sub_mul_unit

`default_nettype wire
